// File: hdl/dequ_pkg.sv
// Shared constants, codes and the cell command type for the deque.
package dequ_pkg;

    localparam int DEQ_DEPTH      = 64;
    localparam int DEQ_DATA_WIDTH = 32;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WRITE      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Broadcast to every cell; the cell compares the shared position with its own.
    typedef struct packed {
        logic load;    // cell at pos takes the input word
        logic grow;    // cells above pos take their lower neighbor
        logic shrink;  // cells at or above pos take their upper neighbor
    } cell_cmd_t;

endpackage

// File: hdl/double_ended_queue_unit.sv
// Top level of the deque: control block plus a chain of element cells.
//
//  channel | beat fields                  | handshake
//  --------+------------------------------+---------------------
//  input   | mode, index, value           | in_valid / in_ready
//  output  | read_value, count, status    | out_valid / out_ready
//
// One beat per cycle: every mode finishes in the cycle it is accepted. The
// cell chain shifts elements for push front, pop front, insert and erase
// in that same cycle, each cell taking from its lower or upper neighbor.
// Results sit in one output register; a new beat is taken whenever that
// register is empty or being drained, so a stalled output holds input off.
// Reset clears the element count and output valid; cell contents are not
// reset, since a slot is only read after it was written.
module double_ended_queue_unit
    import dequ_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int DATA_WIDTH = DEQ_DATA_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [MODE_W-1:0]          mode,
    input  logic [INDEX_W-1:0]         index,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  read_value,
    output logic [COUNT_W-1:0]         count,
    output logic [STATUS_W-1:0]        status
);

    localparam int PW = $clog2(DEPTH);

    cell_cmd_t             cmd;
    logic [PW-1:0]         pos;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [DATA_WIDTH+VALUE_W-1:0] value_wide;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_hit  [DEPTH];

    // keep the low DATA_WIDTH bits of the value, zero above bit 31
    assign value_wide = {{DATA_WIDTH{1'b0}}, value};
    assign word       = value_wide[DATA_WIDTH-1:0];

    dequ_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PW         (PW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .index      (index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .count      (count),
        .status     (status),
        .cmd        (cmd),
        .pos        (pos),
        .rd_word    (rd_word)
    );

    // Cell 0 is the front. Its lower neighbor is a constant; the last cell
    // feeds back on itself when the chain shifts toward the front.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower_data;
        logic [DATA_WIDTH-1:0] upper_data;

        if (g == 0)
        begin : g_first
            assign lower_data = '0;
        end
        else
        begin : g_mid_lo
            assign lower_data = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign upper_data = cell_data[g];
        end
        else
        begin : g_mid_hi
            assign upper_data = cell_data[g+1];
        end

        dequ_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (PW),
            .POS        (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos),
            .word       (word),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .data       (cell_data[g]),
            .hit_data   (cell_hit[g])
        );
    end

    // OR of the read bus; only the addressed cell is nonzero
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | cell_hit[i];
        end
    end

endmodule

// File: hdl/dequ_cell.sv
// One element slot of the deque chain.
module dequ_cell
    import dequ_pkg::*;
#(
    parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
    parameter int PW         = 6,
    parameter int POS        = 0
)
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic [PW-1:0]         pos,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] lower_data,
    input  logic [DATA_WIDTH-1:0] upper_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] hit_data
);

    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.load && pos == MY_POS)
        begin
            data_next = word;
        end
        else if (cmd.grow && MY_POS > pos)
        begin
            data_next = lower_data;
        end
        else if (cmd.shrink && MY_POS >= pos)
        begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // AND-OR read bus: only the addressed cell drives nonzero
    assign hit_data = (pos == MY_POS) ? data_reg : '0;

endmodule

// File: hdl/dequ_ctrl.sv
// Element count, mode decode, status and the result register.
module dequ_ctrl
    import dequ_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
    parameter int PW         = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [INDEX_W-1:0]    index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_W-1:0]    read_value,
    output logic [COUNT_W-1:0]    count,
    output logic [STATUS_W-1:0]   status,
    output cell_cmd_t             cmd,
    output logic [PW-1:0]         pos,
    input  logic [DATA_WIDTH-1:0] rd_word
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  rv_reg, rv_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                accept;
    logic                full, empty, idx_lt, idx_le;
    logic [CMP_W-1:0]    idx_ext, cnt_ext;
    logic [STATUS_W-1:0] st;
    logic                rd_ok;
    logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;
    logic [CNT_W+COUNT_W-1:0]      cnt_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign idx_ext = CMP_W'(index);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign idx_lt  = idx_ext < cnt_ext;
    assign idx_le  = idx_ext <= cnt_ext;

    always_comb
    begin
        st       = ST_OK;
        cmd      = '0;
        pos      = idx_ext[PW-1:0];
        cnt_next = cnt_reg;
        rd_ok    = 1'b0;
        unique case (mode)
            MODE_PUSH_BACK:
            begin
                pos = cnt_reg[PW-1:0];
                if (full) st = ST_FULL;
                else begin cmd.load = 1'b1; cnt_next = cnt_reg + 1'b1; end
            end
            MODE_PUSH_FRONT:
            begin
                pos = '0;
                if (full) st = ST_FULL;
                else
                begin
                    cmd.load = 1'b1;
                    cmd.grow = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_POP_BACK:
            begin
                if (empty) st = ST_EMPTY;
                else cnt_next = cnt_reg - 1'b1;
            end
            MODE_POP_FRONT:
            begin
                pos = '0;
                if (empty) st = ST_EMPTY;
                else begin cmd.shrink = 1'b1; cnt_next = cnt_reg - 1'b1; end
            end
            MODE_READ:
            begin
                if (!idx_lt) st = ST_RANGE;
                else rd_ok = 1'b1;
            end
            MODE_WRITE:
            begin
                if (!idx_lt) st = ST_RANGE;
                else cmd.load = 1'b1;
            end
            MODE_INSERT:
            begin
                if (full) st = ST_FULL;
                else if (!idx_le) st = ST_RANGE;
                else
                begin
                    cmd.load = 1'b1;
                    cmd.grow = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_ERASE:
            begin
                if (empty) st = ST_EMPTY;
                else if (!idx_lt) st = ST_RANGE;
                else begin cmd.shrink = 1'b1; cnt_next = cnt_reg - 1'b1; end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
        if (!accept)
        begin
            cmd      = '0;
            cnt_next = cnt_reg;
        end
    end

    // sign-extend from DATA_WIDTH, keep the low word
    assign rd_ext   = {{VALUE_W{rd_word[DATA_WIDTH-1]}}, rd_word};
    // count port wraps at 7 bits
    assign cnt_wide = (CNT_W+COUNT_W)'(cnt_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        rv_next        = rv_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            rv_next        = rd_ok ? rd_ext[VALUE_W-1:0] : '0;
            count_next     = cnt_wide[COUNT_W-1:0];
            status_next    = st;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg     <= rv_next;
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = rv_reg;
    assign count      = count_reg;
    assign status     = status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("element count above capacity");

    a_cmd_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load || cmd.grow || cmd.shrink) |-> accept)
        else $error("cell command without an accepted beat");

    a_no_grow_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.grow && cmd.shrink))
        else $error("chain told to shift both ways");

    a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && st != ST_OK) |=> cnt_reg == $past(cnt_reg))
        else $error("count changed on an error beat");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_PUSH_BACK && !full)
            |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push back did not grow the count");

endmodule
